// File: hdl/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

  // TEA round constant and default round count
  localparam logic [31:0] TeaDelta = 32'h9E37_79B9;
  localparam int unsigned RoundCountDef = 32;

  // Depth of the input queue in the front that feeds the round engine
  localparam int unsigned QueueDepth = 2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgKeyWord0   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyWord1   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyWord2   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyWord3   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgChainIv    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDecryptMode = 3'd5;

  // One queued input block
  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
    logic        last;
  } item_t;

  // Configuration as seen by the round engine
  typedef struct packed {
    logic [3:0][31:0] key;
    logic [63:0]      iv;
    logic             decrypt;
  } cfg_t;

endpackage

`default_nettype wire

// File: hdl/tcc_front.sv
`default_nettype none

module tcc_front #(
  parameter int unsigned Depth = tcc_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  tcc_pkg::item_t     item_i,
  output logic               item_valid_o,
  output tcc_pkg::item_t     item_o,
  input  wire logic          item_take_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tcc_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_en, rd_en;

  // Handshake on both sides
  assign full         = (cnt_q == FullCnt);
  assign wr_en        = push && !full;
  assign item_valid_o = (cnt_q != '0);
  assign rd_en        = item_take_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTH
  // Fill count never exceeds the queue depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("front queue overfilled");
`endif

endmodule

`default_nettype wire

// File: hdl/tcc_engine.sv
`default_nettype none

module tcc_engine #(
  parameter int unsigned ROUND_COUNT = tcc_pkg::RoundCountDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  tcc_pkg::cfg_t      cfg_i,
  input  wire logic          item_valid_i,
  input  tcc_pkg::item_t     item_i,
  output logic               item_take_o,
  input  wire logic          res_pop_i,
  output logic               res_valid_o,
  output logic [31:0]        res_first_o,
  output logic [31:0]        res_second_o
);

  localparam int unsigned StepCount = 2 * ROUND_COUNT;
  localparam int unsigned StepW = (StepCount > 1) ? $clog2(StepCount) : 1;
  localparam logic [StepW-1:0] LastStep = StepW'(StepCount - 1);
  localparam logic [31:0] SumStart =
    32'(64'(tcc_pkg::TeaDelta) * 64'(ROUND_COUNT));

  // TEA half-round mixing function
  function automatic logic [31:0] mix_half(input logic [31:0] w, input logic [31:0] sum,
                                           input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] hi;
    logic [31:0] lo;
    hi = {w[27:0], 4'b0000};
    lo = {5'b00000, w[31:5]};
    return (hi + ka) ^ (w + sum) ^ (lo + kb);
  endfunction

  logic             busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  logic             res_valid_q, res_valid_d;
  logic             start_q, start_d;
  logic [63:0]      chain_q, chain_d;
  logic [31:0]      a_q, b_q, sum_q;
  logic             mode_q, last_q;
  logic [63:0]      xor_q;
  logic [63:0]      res_q;

  logic        upd_a;
  logic [31:0] w, tgt, ka, kb, mix, new_val, a_n, b_n;
  logic        last_step, hold, step_en, finish, take, res_pop;
  logic [63:0] cv, blk, pre, res_val;

  // Shared half-round unit: even steps update one word, odd steps the other
  always_comb begin
    upd_a   = ~step_q[0] ^ mode_q;
    w       = upd_a ? b_q : a_q;
    tgt     = upd_a ? a_q : b_q;
    ka      = upd_a ? cfg_i.key[0] : cfg_i.key[2];
    kb      = upd_a ? cfg_i.key[1] : cfg_i.key[3];
    mix     = mix_half(w, sum_q, ka, kb);
    new_val = mode_q ? (tgt - mix) : (tgt + mix);
    a_n     = upd_a ? new_val : a_q;
    b_n     = upd_a ? b_q : new_val;
  end

  // Sequencing
  assign last_step   = (step_q == LastStep);
  assign res_pop     = res_pop_i && res_valid_q;
  assign hold        = last_step && res_valid_q && !res_pop_i;
  assign step_en     = busy_q && !hold;
  assign finish      = step_en && last_step;
  assign take        = item_valid_i && !busy_q;
  assign item_take_o = take;

  // Chain value and block at load, output at finish
  assign cv      = start_q ? cfg_i.iv : chain_q;
  assign blk     = {item_i.first, item_i.second};
  assign pre     = cfg_i.decrypt ? blk : (blk ^ cv);
  assign res_val = mode_q ? ({a_n, b_n} ^ xor_q) : {a_n, b_n};

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    res_valid_d = res_valid_q;
    start_d     = start_q;
    chain_d     = chain_q;
    if (take) begin
      busy_d  = 1'b1;
      step_d  = '0;
      start_d = 1'b0;
      if (cfg_i.decrypt) begin
        chain_d = blk;
      end
    end else if (step_en) begin
      step_d = step_q + 1'b1;
      if (finish) begin
        busy_d  = 1'b0;
        start_d = last_q;
        if (!mode_q) begin
          chain_d = {a_n, b_n};
        end
      end
    end
    if (finish) begin
      res_valid_d = 1'b1;
    end else if (res_pop) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
      start_q     <= 1'b1;
      chain_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      res_valid_q <= res_valid_d;
      start_q     <= start_d;
      chain_q     <= chain_d;
    end
  end

  // Working words, round sum and result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      a_q    <= pre[63:32];
      b_q    <= pre[31:0];
      sum_q  <= cfg_i.decrypt ? SumStart : tcc_pkg::TeaDelta;
      mode_q <= cfg_i.decrypt;
      last_q <= item_i.last;
      xor_q  <= cv;
    end else if (step_en) begin
      a_q <= a_n;
      b_q <= b_n;
      if (step_q[0]) begin
        sum_q <= mode_q ? (sum_q - tcc_pkg::TeaDelta) : (sum_q + tcc_pkg::TeaDelta);
      end
    end
    if (finish) begin
      res_q <= res_val;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_first_o  = res_q[63:32];
  assign res_second_o = res_q[31:0];

`ifndef SYNTH
  // A new block is loaded only into an idle engine
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !busy_q) else $error("block loaded while engine busy");
  // The engine stays busy until its last step
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !last_step |=> busy_q) else $error("engine dropped a block");
  // A finished result is kept until it is popped
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_pop_i |=> res_valid_q && $stable(res_q))
    else $error("result lost before pop");
`endif

endmodule

`default_nettype wire

// File: hdl/tea_cbc_cipher.sv
// TEA block cipher in cipher block chaining mode with a 128-bit key. Each
// input transaction carries one 64-bit block as two 32-bit words; each output
// transaction returns one processed block, in order. The user must write keys,
// IV and mode through the cfg port only while the block is idle; the block
// itself does not enforce this. Blocks enter a two-entry input queue and are
// worked by a single shared half-round unit, one half-round per cycle unless
// the engine holds its last step for an unpopped result. The engine takes a
// new block only after it has finished the current one. A finished block
// waits in an output register while the engine starts on the next one. The
// chain starts from the IV after reset and again after a block marked last.
`default_nettype none

module tea_cbc_cipher #(
  parameter int unsigned ROUND_COUNT = tcc_pkg::RoundCountDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [31:0]                 block_first_i,
  input  wire logic [31:0]                 block_second_i,
  input  wire logic                        last_block_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [31:0]                      result_first_o,
  output logic [31:0]                      result_second_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [tcc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [63:0]                 cfg_data_i
);

  tcc_pkg::cfg_t  cfg_q, cfg_d;
  tcc_pkg::item_t in_item, q_item;
  logic           q_valid, q_take, res_valid;

  // Configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tcc_pkg::CfgKeyWord0:    cfg_d.key[0]  = cfg_data_i[31:0];
        tcc_pkg::CfgKeyWord1:    cfg_d.key[1]  = cfg_data_i[31:0];
        tcc_pkg::CfgKeyWord2:    cfg_d.key[2]  = cfg_data_i[31:0];
        tcc_pkg::CfgKeyWord3:    cfg_d.key[3]  = cfg_data_i[31:0];
        tcc_pkg::CfgChainIv:     cfg_d.iv      = cfg_data_i;
        tcc_pkg::CfgDecryptMode: cfg_d.decrypt = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_item = '{first: block_first_i, second: block_second_i, last: last_block_i};

  // Input queue
  tcc_front #(
    .Depth(tcc_pkg::QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .item_i       (in_item),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .item_take_i  (q_take)
  );

  // Round engine with chaining and result register
  tcc_engine #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_take_o  (q_take),
    .res_pop_i    (pop),
    .res_valid_o  (res_valid),
    .res_first_o  (result_first_o),
    .res_second_o (result_second_o)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire
